/* design/assert_macros.svh */
// Assertion macros shared by the queue RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check an implication on every rising clock edge outside reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

/* design/oqte_pkg.sv */
// Package for the ordered queue with tag extract: constants, codes, types.
// No dependencies; used by the interfaces, the cell and the top level.
package oqte_pkg;

   localparam int QUEUE_DEPTH_DEF = 128;
   localparam int TAG_BITS_DEF    = 32;
   localparam int DATA_W          = 32;
   localparam int COUNT_OUT_W     = 8;
   localparam int THR_W           = 8;
   localparam logic [THR_W-1:0] WARN_RESET = 8'd100;

   // Request codes; code 3 is unused and changes nothing
   localparam logic [1:0] REQ_PUSH       = 2'd0;
   localparam logic [1:0] REQ_PULL_FRONT = 2'd1;
   localparam logic [1:0] REQ_PULL_TAG   = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } oqte_state_type;

   // Per-cell load controls
   typedef struct packed {
      logic take_above;
      logic take_push;
   } oqte_cell_cmd_type;

endpackage

/* design/oqte_req_if.sv */
// Request channel interface: valid/ready plus request word.
// Depends on oqte_pkg.
interface oqte_req_if;
   import oqte_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [1:0]               req_type;
   logic signed [DATA_W-1:0] entry_tag;
   logic signed [DATA_W-1:0] entry_value;

   modport source (output valid, req_type, entry_tag, entry_value, input ready);
   modport sink   (input valid, req_type, entry_tag, entry_value, output ready);
endinterface

/* design/oqte_rsp_if.sv */
// Response channel interface: valid/ready plus result word.
// Depends on oqte_pkg.
interface oqte_rsp_if;
   import oqte_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     found;
   logic signed [DATA_W-1:0] out_tag;
   logic signed [DATA_W-1:0] out_value;
   logic [COUNT_OUT_W-1:0]   queue_count;
   logic                     over_threshold;
   logic                     push_refused;

   modport source (output valid, found, out_tag, out_value, queue_count,
                   over_threshold, push_refused, input ready);
   modport sink   (input valid, found, out_tag, out_value, queue_count,
                   over_threshold, push_refused, output ready);
endinterface

/* design/oqte_cell.sv */
// One queue slot: tag, value and valid, loaded from the next-younger
// neighbor on a shift or from the push word. Depends on oqte_pkg.
module oqte_cell #(
   parameter int TAG_W = oqte_pkg::TAG_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  oqte_pkg::oqte_cell_cmd_type      cmd,
   input  logic [TAG_W-1:0]                 above_tag,
   input  logic [oqte_pkg::DATA_W-1:0]      above_value,
   input  logic                             above_valid,
   input  logic [TAG_W-1:0]                 push_tag,
   input  logic [oqte_pkg::DATA_W-1:0]      push_value,
   input  logic [TAG_W-1:0]                 key_tag,
   output logic [TAG_W-1:0]                 tag,
   output logic [oqte_pkg::DATA_W-1:0]      value,
   output logic                             valid,
   output logic                             tag_eq
);
   import oqte_pkg::*;

   logic [TAG_W-1:0]  tag_ff;
   logic [DATA_W-1:0] value_ff;
   logic              valid_ff;

   // Valid: shift wins over push; push only lands on the first empty slot
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.take_above) begin
         valid_ff <= above_valid;
      end else if (cmd.take_push) begin
         valid_ff <= 1'b1;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      if (cmd.take_above) begin
         tag_ff   <= above_tag;
         value_ff <= above_value;
      end else if (cmd.take_push) begin
         tag_ff   <= push_tag;
         value_ff <= push_value;
      end
   end

   assign tag    = tag_ff;
   assign value  = value_ff;
   assign valid  = valid_ff;
   assign tag_eq = valid_ff && (tag_ff == key_tag);

endmodule

/* design/ordered_queue_with_tag_extract.sv */
// Ordered queue with keyed removal: a row of slot cells, oldest in cell 0.
// Each request is an accept (cells compare the tag, or take the head slot for
// a front pull; hits registered), then an execute (lowest hit removed, cells
// above shift down, or a push fills the first empty slot); no new request is
// taken until execute ends. A full response register stalls execution until
// the word is taken. Sync active-high reset empties queue, sets threshold 100.
module ordered_queue_with_tag_extract #(
   parameter int QUEUE_DEPTH = oqte_pkg::QUEUE_DEPTH_DEF,
   parameter int TAG_BITS    = oqte_pkg::TAG_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   oqte_req_if.sink                      req_chan,
   oqte_rsp_if.source                    rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [oqte_pkg::THR_W-1:0]    csr_wr_data
);
   import oqte_pkg::*;
   `include "assert_macros.svh"

   localparam int TAG_W = (TAG_BITS < DATA_W) ? TAG_BITS : DATA_W;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   oqte_state_type state_ff, state_in;

   logic [1:0]             op_ff;
   logic [TAG_W-1:0]       ptag_ff;
   logic [DATA_W-1:0]      pval_ff;
   logic [QUEUE_DEPTH-1:0] hit_ff, hit_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [THR_W-1:0]       thr_ff;

   logic                   rsp_valid_ff;
   logic                   rsp_found_ff;
   logic [DATA_W-1:0]      rsp_tag_ff;
   logic [DATA_W-1:0]      rsp_value_ff;
   logic [COUNT_OUT_W-1:0] rsp_count_ff;
   logic                   rsp_over_ff;
   logic                   rsp_refused_ff;

   logic                   req_ready_w, exec_active, exec_go, req_fire, rsp_fire;
   logic                   full_w, push_go, found_w;
   logic [QUEUE_DEPTH-1:0] first_oh, below_mask, valid_vec, eq_vec;
   logic [TAG_W-1:0]       key_tag;
   logic [TAG_W-1:0]       sel_tag;
   logic [DATA_W-1:0]      sel_value, otag_ext;
   logic [CNT_W+COUNT_OUT_W-1:0] count_ext, thr_ext;

   logic [TAG_W-1:0]       cell_tag   [QUEUE_DEPTH];
   logic [DATA_W-1:0]      cell_value [QUEUE_DEPTH];
   oqte_cell_cmd_type      cell_cmd   [QUEUE_DEPTH];

   // FSM next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_fire) state_in = ST_EXEC;
         ST_EXEC: if (exec_go) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // FSM outputs
   always_comb begin
      req_ready_w = 1'b0;
      exec_active = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_ready_w = 1'b1;
         ST_EXEC: exec_active = 1'b1;
         default: ;
      endcase
   end

   assign req_chan.ready = req_ready_w;
   assign req_fire = req_chan.valid && req_ready_w;
   assign rsp_fire = rsp_valid_ff && rsp_chan.ready;
   assign exec_go  = exec_active && (!rsp_valid_ff || rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // Threshold register
   always_ff @(posedge clock) begin
      if (reset)          thr_ff <= WARN_RESET;
      else if (csr_wr_en) thr_ff <= csr_wr_data;
   end

   // Hit vector at accept: tag compare in every cell, or the head slot
   assign key_tag = req_chan.entry_tag[TAG_W-1:0];
   always_comb begin
      unique case (req_chan.req_type)
         REQ_PULL_TAG:   hit_in = eq_vec;
         REQ_PULL_FRONT: hit_in = valid_vec & QUEUE_DEPTH'(1);
         default:        hit_in = '0;
      endcase
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= '0;
      end else if (req_fire) begin
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff   <= req_chan.req_type;
         ptag_ff <= key_tag;
         pval_ff <= req_chan.entry_value;
      end
   end

   // Lowest hit and the slots below it
   assign first_oh   = hit_ff & (~hit_ff + QUEUE_DEPTH'(1));
   assign below_mask = first_oh - QUEUE_DEPTH'(1);
   assign found_w    = |hit_ff;
   assign full_w     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign push_go    = exec_go && (op_ff == REQ_PUSH) && !full_w;

   // Removed entry select
   always_comb begin
      sel_tag   = '0;
      sel_value = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         sel_tag   = sel_tag   | ({TAG_W{first_oh[i]}}  & cell_tag[i]);
         sel_value = sel_value | ({DATA_W{first_oh[i]}} & cell_value[i]);
      end
   end

   // Cell row
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic [TAG_W-1:0]  up_tag;
      logic [DATA_W-1:0] up_value;
      logic              up_valid;
      logic              prev_valid;

      if (i == QUEUE_DEPTH - 1) begin : g_top
         assign up_tag   = '0;
         assign up_value = '0;
         assign up_valid = 1'b0;
      end else begin : g_mid
         assign up_tag   = cell_tag[i+1];
         assign up_value = cell_value[i+1];
         assign up_valid = valid_vec[i+1];
      end

      if (i == 0) begin : g_head
         assign prev_valid = 1'b1;
      end else begin : g_rest
         assign prev_valid = valid_vec[i-1];
      end

      assign cell_cmd[i].take_above = exec_go && found_w && !below_mask[i];
      assign cell_cmd[i].take_push  = push_go && !valid_vec[i] && prev_valid;

      oqte_cell #(
         .TAG_W (TAG_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cell_cmd[i]),
         .above_tag   (up_tag),
         .above_value (up_value),
         .above_valid (up_valid),
         .push_tag    (ptag_ff),
         .push_value  (pval_ff),
         .key_tag     (key_tag),
         .tag         (cell_tag[i]),
         .value       (cell_value[i]),
         .valid       (valid_vec[i]),
         .tag_eq      (eq_vec[i])
      );
   end

   // Entry count
   always_comb begin
      count_in = count_ff;
      if (push_go)                      count_in = count_ff + CNT_W'(1);
      else if (exec_go && found_w)      count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else       count_ff <= count_in;
   end

   assign count_ext = {{COUNT_OUT_W{1'b0}}, count_in};
   assign thr_ext   = {{CNT_W{1'b0}}, thr_ff};

   always_comb begin
      otag_ext = '0;
      otag_ext[TAG_W-1:0] = sel_tag;
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_fire) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_go) begin
         rsp_found_ff   <= found_w;
         rsp_tag_ff     <= otag_ext;
         rsp_value_ff   <= sel_value;
         rsp_count_ff   <= count_ext[COUNT_OUT_W-1:0];
         rsp_over_ff    <= (count_ext > thr_ext);
         rsp_refused_ff <= (op_ff == REQ_PUSH) && full_w;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.found          = rsp_found_ff;
   assign rsp_chan.out_tag        = rsp_tag_ff;
   assign rsp_chan.out_value      = rsp_value_ff;
   assign rsp_chan.queue_count    = rsp_count_ff;
   assign rsp_chan.over_threshold = rsp_over_ff;
   assign rsp_chan.push_refused   = rsp_refused_ff;

   // Occupied slots stay packed at the head
   `ASSERT_CLK(a_packed, ((valid_vec >> 1) & ~valid_vec) == '0, "queue slots not packed")
   // Count tracks the occupied slots
   `ASSERT_CLK(a_count, $countones(valid_vec) == count_ff, "count disagrees with slots")
   // A hit removal shrinks the queue by one
   `ASSERT_IMPLY(a_remove, exec_go && found_w, ##1 (count_ff == $past(count_ff) - CNT_W'(1)),
      "removal did not shrink queue")

endmodule
